### rtl/core/ssq_pkg.sv
// Shared types and constants of the submatrix sum block.
// No dependencies; used by the top level and its checker.
`default_nettype none
package ssq_pkg;

    localparam int ELEM_W = 32;
    localparam int SUM_W  = 40;
    localparam int IDX_W  = 4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

endpackage
`default_nettype wire

### rtl/core/submatrix_sum_query.sv
// Top level of the submatrix sum block: matrix store, scan sequencer, accumulator.
// Depends on ssq_pkg and ssq_ram.
//
// Usage:
//   An item is taken at a rising edge with start high and busy low.
//   operation selects a write (store write_value at write_row, write_col) or
//   a query (sum of the rectangle top_row..bottom_row, left_col..right_col).
//   A write is stored at the accepting edge, gives no result and leaves busy
//   low, so writes can be taken every cycle. A write outside the matrix is
//   dropped.
//   A query clips its bounds to the matrix and then reads one element per
//   cycle from the single read port of the store. After the last read the
//   sequencer passes through ST_DRAIN, where that element is added, to
//   ST_DONE, where done pulses for one cycle with the sum on rect_sum (an
//   empty rectangle goes to ST_DONE the very next cycle and returns zero);
//   busy drops as that pulse ends. The result beat on rect_sum cannot be
//   held off by the receiver.
//   Reset clears the sequencer only; the store content is undefined until
//   written.
`default_nettype none
module submatrix_sum_query #(
    parameter int ROWS = 16,
    parameter int COLS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        operation,
    input  wire logic [3:0]  write_row,
    input  wire logic [3:0]  write_col,
    input  wire logic signed [31:0] write_value,
    input  wire logic [3:0]  top_row,
    input  wire logic [3:0]  left_col,
    input  wire logic [3:0]  bottom_row,
    input  wire logic [3:0]  right_col,
    output logic             done,
    output logic signed [39:0] rect_sum
);

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW    = 12;
    localparam logic [ssq_pkg::IDX_W-1:0] ROW_MAX =
        (ROWS > 16) ? 4'd15 : ssq_pkg::IDX_W'(ROWS - 1);
    localparam logic [ssq_pkg::IDX_W-1:0] COL_MAX =
        (COLS > 16) ? 4'd15 : ssq_pkg::IDX_W'(COLS - 1);
    localparam logic [MW-1:0] COLS_M = MW'(COLS);

    ssq_pkg::state_t state_reg, state_next;

    logic [ssq_pkg::IDX_W-1:0] row_reg, row_next;
    logic [ssq_pkg::IDX_W-1:0] col_reg, col_next;
    logic [ssq_pkg::IDX_W-1:0] left_reg, left_next;
    logic [ssq_pkg::IDX_W-1:0] right_reg, right_next;
    logic [ssq_pkg::IDX_W-1:0] bottom_reg, bottom_next;
    logic                      rvalid_reg, rvalid_next;
    logic [ssq_pkg::SUM_W-1:0] acc_reg, acc_next;

    logic                      accept;
    logic [ssq_pkg::IDX_W-1:0] bottom_clip;
    logic [ssq_pkg::IDX_W-1:0] right_clip;
    logic                      wr_in_range;
    logic                      ram_we;
    logic                      ram_re;
    logic [MW-1:0]             waddr_full;
    logic [MW-1:0]             raddr_full;
    logic [ssq_pkg::ELEM_W-1:0] ram_rdata;
    logic                      last_addr;

    assign accept      = start && !busy;
    assign bottom_clip = (bottom_row > ROW_MAX) ? ROW_MAX : bottom_row;
    assign right_clip  = (right_col > COL_MAX) ? COL_MAX : right_col;
    assign wr_in_range = (write_row <= ROW_MAX) && (write_col <= COL_MAX)
                         && (7'(write_row) < 7'(ROWS)) && (7'(write_col) < 7'(COLS));
    assign ram_we      = accept && (operation == ssq_pkg::OP_WRITE) && wr_in_range;
    assign ram_re      = (state_reg == ssq_pkg::ST_SCAN);
    assign waddr_full  = MW'(write_row) * COLS_M + MW'(write_col);
    assign raddr_full  = MW'(row_reg) * COLS_M + MW'(col_reg);
    assign last_addr   = (row_reg == bottom_reg) && (col_reg == right_reg);

    ssq_ram #(
        .WIDTH (ssq_pkg::ELEM_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr_full[AW-1:0]),
        .wdata (write_value),
        .re    (ram_re),
        .raddr (raddr_full[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        bottom_next = bottom_reg;
        rvalid_next = 1'b0;
        acc_next    = acc_reg;

        // add the beat read in the previous cycle
        if (rvalid_reg)
        begin
            acc_next = acc_reg + {{(ssq_pkg::SUM_W - ssq_pkg::ELEM_W){ram_rdata[31]}},
                                  ram_rdata};
        end

        unique case (state_reg)
            ssq_pkg::ST_IDLE:
            begin
                if (accept && (operation == ssq_pkg::OP_QUERY))
                begin
                    acc_next    = '0;
                    row_next    = top_row;
                    col_next    = left_col;
                    left_next   = left_col;
                    right_next  = right_clip;
                    bottom_next = bottom_clip;
                    if ((top_row > bottom_clip) || (left_col > right_clip))
                    begin
                        state_next = ssq_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = ssq_pkg::ST_SCAN;
                    end
                end
            end
            ssq_pkg::ST_SCAN:
            begin
                rvalid_next = 1'b1;
                if (last_addr)
                begin
                    state_next = ssq_pkg::ST_DRAIN;
                end
                else if (col_reg == right_reg)
                begin
                    col_next = left_reg;
                    row_next = row_reg + 4'd1;
                end
                else
                begin
                    col_next = col_reg + 4'd1;
                end
            end
            ssq_pkg::ST_DRAIN:
            begin
                state_next = ssq_pkg::ST_DONE;
            end
            ssq_pkg::ST_DONE:
            begin
                state_next = ssq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ssq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ssq_pkg::ST_IDLE;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg    <= row_next;
        col_reg    <= col_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        bottom_reg <= bottom_next;
        acc_reg    <= acc_next;
    end

    assign busy     = (state_reg != ssq_pkg::ST_IDLE);
    assign done     = (state_reg == ssq_pkg::ST_DONE);
    assign rect_sum = acc_reg;

endmodule
`default_nettype wire

### rtl/core/ssq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module ssq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### rtl/core/ssq_checker.sv
// Port-level checks of the submatrix sum block, bound to the top level.
// Depends on ssq_pkg.
`default_nettype none
module ssq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        operation,
    input wire logic [3:0]  top_row,
    input wire logic [3:0]  left_col,
    input wire logic [3:0]  bottom_row,
    input wire logic [3:0]  right_col,
    input wire logic        done,
    input wire logic [39:0] rect_sum
);

    // a result beat only appears while a query holds the block
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done outside a query");

    // one beat per query, then the block frees up
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result beat not single or block not freed");

    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == ssq_pkg::OP_WRITE)) |=> (!busy && !done))
        else $error("write held the block or gave a result");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == ssq_pkg::OP_QUERY)) |=> busy)
        else $error("query not taken");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == ssq_pkg::OP_QUERY) &&
         ((top_row > bottom_row) || (left_col > right_col)))
        |=> (done && (rect_sum == '0)))
        else $error("empty rectangle did not return zero");

endmodule

bind submatrix_sum_query ssq_checker u_ssq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .operation  (operation),
    .top_row    (top_row),
    .left_col   (left_col),
    .bottom_row (bottom_row),
    .right_col  (right_col),
    .done       (done),
    .rect_sum   (rect_sum)
);
`default_nettype wire

### dv/tb.sv
// Testbench for submatrix_sum_query: drives writes and rectangle queries, mirrors the matrix
// and checks every rect_sum beat against a locally computed sum.
// Depends on ssq_pkg and the submatrix_sum_query RTL.
module tb;

    localparam int ROWS        = 16;
    localparam int COLS        = 16;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic                operation;
        logic [3:0]          write_row;
        logic [3:0]          write_col;
        logic signed [31:0]  write_value;
        logic [3:0]          top_row;
        logic [3:0]          left_col;
        logic [3:0]          bottom_row;
        logic [3:0]          right_col;
        bit                  hold_for_results;
    } ssq_item_t;

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                start       = 1'b0;
    logic                operation   = ssq_pkg::OP_WRITE;
    logic [3:0]          write_row   = '0;
    logic [3:0]          write_col   = '0;
    logic signed [31:0]  write_value = '0;
    logic [3:0]          top_row     = '0;
    logic [3:0]          left_col    = '0;
    logic [3:0]          bottom_row  = '0;
    logic [3:0]          right_col   = '0;
    logic                busy;
    logic                done;
    logic signed [39:0]  rect_sum;

    ssq_item_t           stim_items[$];
    ssq_item_t           cur;
    logic signed [39:0]  sum_expected[$];
    logic signed [31:0]  elem_mirror[ROWS][COLS];
    bit                  cell_loaded[ROWS][COLS];
    int                  idle_left   = 0;
    int                  burst_left  = 0;
    int                  idle_cycles = 0;
    int                  errors      = 0;

    submatrix_sum_query #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .write_row  (write_row),
        .write_col  (write_col),
        .write_value(write_value),
        .top_row    (top_row),
        .left_col   (left_col),
        .bottom_row (bottom_row),
        .right_col  (right_col),
        .done       (done),
        .rect_sum   (rect_sum)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Sum of the mirrored elements in the clipped rectangle, wrapped to 40 bits.
    function automatic logic signed [39:0] rect_total(input logic [3:0] t, l, b, r);
        longint acc;
        int     bot;
        int     rgt;
        acc = 0;
        bot = (int'(b) > ROWS - 1) ? ROWS - 1 : int'(b);
        rgt = (int'(r) > COLS - 1) ? COLS - 1 : int'(r);
        if (int'(t) <= bot && int'(l) <= rgt)
        begin
            for (int i = t; i <= bot; i++)
                for (int j = l; j <= rgt; j++)
                    acc += elem_mirror[i][j];
        end
        return acc[39:0];
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return $signed($urandom_range(0, 200)) - 100;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_gap();
        int roll;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Unused fields of each beat get random content so every input bit toggles.
    function automatic void add_write(input logic [3:0] r, c, input logic signed [31:0] v);
        ssq_item_t it;
        it.operation        = ssq_pkg::OP_WRITE;
        it.write_row        = r;
        it.write_col        = c;
        it.write_value      = v;
        it.top_row          = $urandom_range(0, 15);
        it.left_col         = $urandom_range(0, 15);
        it.bottom_row       = $urandom_range(0, 15);
        it.right_col        = $urandom_range(0, 15);
        it.hold_for_results = 1'b0;
        stim_items.push_back(it);
        cell_loaded[r][c] = 1'b1;
    endfunction

    // Load any cell the rectangle covers that was never written, then queue the query.
    function automatic void add_query(input logic [3:0] t, l, b, r, input bit hold);
        ssq_item_t it;
        if (t <= b && l <= r)
        begin
            for (int i = t; i <= b; i++)
                for (int j = l; j <= r; j++)
                    if (!cell_loaded[i][j])
                        add_write(i, j, pick_value());
        end
        it.operation        = ssq_pkg::OP_QUERY;
        it.write_row        = $urandom_range(0, 15);
        it.write_col        = $urandom_range(0, 15);
        it.write_value      = $urandom;
        it.top_row          = t;
        it.left_col         = l;
        it.bottom_row       = b;
        it.right_col        = r;
        it.hold_for_results = hold;
        stim_items.push_back(it);
    endfunction

    // Driver: offer the next beat, hold it until taken, then idle for a random gap.
    always @(posedge clk)
    begin : drive
        bit take;
        take = start && !busy;
        if (rst_n)
        begin
            if (take)
            begin
                if (cur.operation == ssq_pkg::OP_WRITE)
                    elem_mirror[cur.write_row][cur.write_col] = cur.write_value;
                else
                    sum_expected.push_back(rect_total(cur.top_row, cur.left_col,
                                                      cur.bottom_row, cur.right_col));
                idle_left = pick_gap();
            end
            if (start && !take)
            begin
                // hold the current beat
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                start <= 1'b0;
            end
            else if (stim_items.size() > 0
                     && !(stim_items[0].hold_for_results && sum_expected.size() != 0))
            begin
                cur = stim_items.pop_front();
                operation   <= cur.operation;
                write_row   <= cur.write_row;
                write_col   <= cur.write_col;
                write_value <= cur.write_value;
                top_row     <= cur.top_row;
                left_col    <= cur.left_col;
                bottom_row  <= cur.bottom_row;
                right_col   <= cur.right_col;
                start       <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every done beat must match the oldest outstanding query sum.
    always @(posedge clk)
    begin : watch
        logic signed [39:0] want;
        if (rst_n && done)
        begin
            if (sum_expected.size() == 0)
            begin
                $error("rect_sum beat with no query outstanding: actual %0d", rect_sum);
                errors++;
            end
            else
            begin
                want = sum_expected.pop_front();
                if (rect_sum !== want)
                begin
                    $error("rect_sum mismatch: expected %0d, actual %0d", want, rect_sum);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("[submatrix_sum_query] ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int roll;
        int t;
        int l;
        int b;
        int r;

        // Empty rectangles: rows crossed, columns crossed, both.
        add_query(4'd5, 4'd0, 4'd4, 4'd3, 1'b0);
        add_query(4'd0, 4'd9, 4'd3, 4'd2, 1'b0);
        add_query(4'd15, 4'd15, 4'd0, 4'd0, 1'b0);
        add_write(4'd0, 4'd0, 32'sh7fffffff);
        add_query(4'd0, 4'd0, 4'd0, 4'd0, 1'b0);
        add_write(4'd0, 4'd0, 32'sh80000000);
        add_query(4'd0, 4'd0, 4'd0, 4'd0, 1'b1);
        add_write(4'd15, 4'd15, -32'sd1);
        add_query(4'd15, 4'd15, 4'd15, 4'd15, 1'b0);
        add_write(4'd3, 4'd7, 32'sd0);
        add_write(4'd3, 4'd7, 32'sd123);
        add_query(4'd3, 4'd7, 4'd3, 4'd7, 1'b0);
        add_query(4'd0, 4'd0, 4'd1, 4'd1, 1'b0);
        add_query(4'd14, 4'd14, 4'd15, 4'd15, 1'b0);

        while (stim_items.size() < 185)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 35)
            begin
                add_write($urandom_range(0, 15), $urandom_range(0, 15), pick_value());
            end
            else if (roll < 45)
            begin
                add_query($urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 24) == 0);
            end
            else
            begin
                t = $urandom_range(0, 15);
                l = $urandom_range(0, 15);
                if (roll < 90)
                begin
                    b = t + $urandom_range(0, 3);
                    r = l + $urandom_range(0, 3);
                end
                else
                begin
                    b = $urandom_range(t, 15);
                    r = $urandom_range(l, 15);
                end
                if (b > ROWS - 1)
                    b = ROWS - 1;
                if (r > COLS - 1)
                    r = COLS - 1;
                add_query(t, l, b, r, $urandom_range(0, 24) == 0);
            end
        end

        // Saturate the whole matrix at the negative extreme to reach the bottom of the sum range.
        for (int i = 0; i < ROWS; i++)
            for (int j = 0; j < COLS; j++)
                add_write(i, j, 32'sh80000000);
        add_query(4'd0, 4'd0, 4'd15, 4'd15, 1'b1);
        add_query(4'd15, 4'd0, 4'd15, 4'd15, 1'b0);
        add_query(4'd0, 4'd15, 4'd15, 4'd15, 1'b0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_items.size() != 0 || start)
            @(posedge clk);
        while (sum_expected.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (errors == 0 && sum_expected.size() == 0)
            $display("[submatrix_sum_query] OK");
        else
            $display("[submatrix_sum_query] ERROR");
        $finish;
    end
endmodule

### files.f
rtl/core/ssq_pkg.sv
rtl/core/ssq_ram.sv
rtl/core/submatrix_sum_query.sv
rtl/core/ssq_checker.sv
dv/tb.sv
